FILE: hw/rtl/rsoc_pkg.sv
// shared types, constants and mask coefficient functions for reverse subdivision
package rsoc_pkg;

   localparam int WIN_DEPTH  = 9;
   localparam int TAPS       = 7;
   localparam int COORDS     = 3;
   localparam int JOB_COUNT  = 7;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   // one job per coarse point, in output order
   typedef enum logic [2:0] {
      JOB_FIRST  = 3'd0,
      JOB_START5 = 3'd1,
      JOB_START7 = 3'd2,
      JOB_REG    = 3'd3,
      JOB_END7   = 3'd4,
      JOB_END5   = 3'd5,
      JOB_LAST   = 3'd6
   } job_type;

   localparam logic [1:0] KIND_COPY    = 2'd0;
   localparam logic [1:0] KIND_TAP5    = 2'd1;
   localparam logic [1:0] KIND_TAP7    = 2'd2;
   localparam logic [1:0] KIND_REGULAR = 2'd3;

   typedef struct packed {
      logic    valid;
      job_type job;
   } issue_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       last;
   } result_tag_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } pipe_status_type;

   // mask taps in millionths
   function automatic longint start5_micro(input int tap);
      longint v;
      v = 0;
      case (tap)
         0: v = -352518;
         1: v = 705036;
         2: v = 971230;
         3: v = -431655;
         4: v = 107914;
         default: v = 0;
      endcase
      return v;
   endfunction

   function automatic longint start7_micro(input int tap);
      longint v;
      v = 0;
      case (tap)
         0: v = 180000;
         1: v = -360000;
         2: v = -80000;
         3: v = 1280000;
         4: v = 430000;
         5: v = -600000;
         6: v = 150000;
         default: v = 0;
      endcase
      return v;
   endfunction

   function automatic longint reg_micro(input int tap);
      longint v;
      v = 0;
      case (tap)
         0, 6: v = 117347;
         1, 5: v = -469388;
         2, 4: v = 321429;
         3: v = 1061224;
         default: v = 0;
      endcase
      return v;
   endfunction

   // millionths to fixed point, rounding halves away from zero
   function automatic longint coef_fixed(input longint micro, input int frac_bits);
      longint scaled;
      longint mag;
      longint r;
      scaled = micro * (longint'(1) << frac_bits);
      mag = (scaled < 0) ? -scaled : scaled;
      r = (mag + 500000) / 1000000;
      return (scaled < 0) ? -r : r;
   endfunction

   function automatic logic [1:0] job_kind(input job_type job);
      logic [1:0] k;
      k = KIND_COPY;
      case (job)
         JOB_FIRST, JOB_LAST: k = KIND_COPY;
         JOB_START5, JOB_END5: k = KIND_TAP5;
         JOB_START7, JOB_END7: k = KIND_TAP7;
         JOB_REG: k = KIND_REGULAR;
         default: k = KIND_COPY;
      endcase
      return k;
   endfunction

endpackage

FILE: hw/rtl/rsoc_lane.sv
// one tap lane: coefficient select, point select and registered products
module rsoc_lane
   import rsoc_pkg::*;
#(
   parameter int COORD_BITS     = 16,
   parameter int COEF_FRAC_BITS = 14,
   parameter int TAP            = 0
) (
   input  logic                                       clock,
   input  job_type                                    job,
   input  logic signed [COORD_BITS-1:0]               fwd_pt [COORDS],
   input  logic signed [COORD_BITS-1:0]               rev_pt [COORDS],
   output logic signed [COORD_BITS+COEF_FRAC_BITS+1:0] prod  [COORDS]
);

   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int PROD_W = COORD_BITS + COEF_W;

   localparam logic signed [COEF_W-1:0] C_START5 =
      COEF_W'(coef_fixed(start5_micro(TAP), COEF_FRAC_BITS));
   localparam logic signed [COEF_W-1:0] C_START7 =
      COEF_W'(coef_fixed(start7_micro(TAP), COEF_FRAC_BITS));
   localparam logic signed [COEF_W-1:0] C_REG =
      COEF_W'(coef_fixed(reg_micro(TAP), COEF_FRAC_BITS));
   localparam logic signed [COEF_W-1:0] C_COPY =
      (TAP == 0) ? COEF_W'(longint'(1) << COEF_FRAC_BITS) : COEF_W'(0);

   logic signed [COEF_W-1:0]     coef;
   logic                         use_rev;
   logic signed [COORD_BITS-1:0] sel_pt [COORDS];
   logic signed [PROD_W-1:0]     prod_in [COORDS];
   logic signed [PROD_W-1:0]     prod_ff [COORDS];

   always_comb begin
      coef    = '0;
      use_rev = 1'b0;
      unique case (job)
         JOB_FIRST: begin
            coef = C_COPY;
         end
         JOB_START5: begin
            coef = C_START5;
         end
         JOB_START7: begin
            coef = C_START7;
         end
         JOB_REG: begin
            coef = C_REG;
         end
         JOB_END7: begin
            coef    = C_START7;
            use_rev = 1'b1;
         end
         JOB_END5: begin
            coef    = C_START5;
            use_rev = 1'b1;
         end
         JOB_LAST: begin
            coef    = C_COPY;
            use_rev = 1'b1;
         end
         default: begin
            coef    = '0;
            use_rev = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < COORDS; c++) begin
         sel_pt[c]  = use_rev ? rev_pt[c] : fwd_pt[c];
         prod_in[c] = sel_pt[c] * coef;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < COORDS; c++) begin
         prod_ff[c] <= prod_in[c];
      end
   end

   assign prod = prod_ff;

endmodule

FILE: hw/rtl/rsoc_merge.sv
// merging stage: sums lane products, rounds and saturates each coordinate
module rsoc_merge
   import rsoc_pkg::*;
#(
   parameter int COORD_BITS     = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  issue_type                                  issue,
   input  logic signed [COORD_BITS+COEF_FRAC_BITS+1:0] lane_prod [TAPS][COORDS],
   output pipe_status_type                            status,
   output result_tag_type                             res_tag,
   output logic signed [COORD_BITS-1:0]               res_pt [COORDS]
);

   localparam int PROD_W = COORD_BITS + COEF_FRAC_BITS + 2;
   localparam int SUM_W  = PROD_W + 3;

   localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(longint'(1) << (COEF_FRAC_BITS - 1));
   localparam logic signed [SUM_W-1:0] SAT_HI   =
      SUM_W'((longint'(1) << (COORD_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO   = -SAT_HI - SUM_W'(1);

   logic                     s1_valid_ff, s1_valid_in;
   job_type                  s1_job_ff;
   logic                     s2_valid_ff, s2_valid_in;
   job_type                  s2_job_ff;
   logic signed [SUM_W-1:0]  sum_in [COORDS];
   logic signed [SUM_W-1:0]  sum_ff [COORDS];
   logic signed [SUM_W-1:0]  rnd    [COORDS];
   logic signed [SUM_W-1:0]  quo    [COORDS];

   assign s1_valid_in = issue.valid;
   assign s2_valid_in = s1_valid_ff;

   always_comb begin
      for (int c = 0; c < COORDS; c++) begin
         sum_in[c] = '0;
         for (int t = 0; t < TAPS; t++) begin
            sum_in[c] = sum_in[c] + SUM_W'(lane_prod[t][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_job_ff <= issue.job;
      s2_job_ff <= s1_job_ff;
      for (int c = 0; c < COORDS; c++) begin
         sum_ff[c] <= sum_in[c];
      end
   end

   // halves away from zero: add half, less one when negative, then floor
   always_comb begin
      for (int c = 0; c < COORDS; c++) begin
         rnd[c] = sum_ff[c] + RND_HALF - $signed({{(SUM_W-1){1'b0}}, sum_ff[c][SUM_W-1]});
         quo[c] = rnd[c] >>> COEF_FRAC_BITS;
         if (quo[c] > SAT_HI) begin
            res_pt[c] = COORD_BITS'(SAT_HI);
         end else if (quo[c] < SAT_LO) begin
            res_pt[c] = COORD_BITS'(SAT_LO);
         end else begin
            res_pt[c] = COORD_BITS'(quo[c]);
         end
      end
   end

   assign res_tag.valid   = s2_valid_ff;
   assign res_tag.kind    = job_kind(s2_job_ff);
   assign res_tag.last    = (s2_job_ff == JOB_LAST);
   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

endmodule

FILE: hw/rtl/rsoc_fifo.sv
// result queue between the merging stage and the result channel
module rsoc_fifo
   import rsoc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  result_tag_type               wr_tag,
   input  logic signed [COORD_BITS-1:0] wr_pt [COORDS],
   input  logic                         rd_stall,
   output logic                         rd_valid,
   output logic signed [COORD_BITS-1:0] rd_pt [COORDS],
   output logic [1:0]                   rd_kind,
   output logic                         rd_last,
   output logic [FIFO_CNT_W-1:0]        count
);

   logic signed [COORD_BITS-1:0] pt_ff   [FIFO_DEPTH][COORDS];
   logic [1:0]                   kind_ff [FIFO_DEPTH];
   logic                         last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]        count_ff, count_in;
   logic                         do_rd;
   logic                         do_wr;

   assign do_wr    = wr_tag.valid;
   assign rd_valid = (count_ff != '0);
   assign do_rd    = rd_valid && !rd_stall;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(do_wr) - FIFO_CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         pt_ff[wr_ptr_ff]   <= wr_pt;
         kind_ff[wr_ptr_ff] <= wr_tag.kind;
         last_ff[wr_ptr_ff] <= wr_tag.last;
      end
   end

   assign rd_pt   = pt_ff[rd_ptr_ff];
   assign rd_kind = kind_ff[rd_ptr_ff];
   assign rd_last = last_ff[rd_ptr_ff];
   assign count   = count_ff;

endmodule

FILE: hw/rtl/reverse_subdivision_open_curve_top.sv
// top level of the streamed reverse cubic b-spline subdivision of an open curve
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    pt_x, pt_y, pt_z, end_of_curve
//   rsp      out  rsp_valid/stall    cp_x, cp_y, cp_z, point_kind, last_of_polygon
//
// one item is taken per cycle unless coarse points stay pending after this cycle's issue; an
//   item that needs several of them or a queue out of credit holds req_stall until they go
// a coarse point goes through the lane product and merged sum registers into the 8-entry
//   result queue; stages are lane multiply, lane merge, round and saturate
// reset clears counters, pending jobs, pipeline valids and the queue, not the window
// a stalled result channel backs up the queue; issue stops at its credit, req_stall follows
module reverse_subdivision_open_curve_top
   import rsoc_pkg::*;
#(
   parameter int COORD_BITS     = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_pt_x,
   input  logic signed [COORD_BITS-1:0] req_pt_y,
   input  logic signed [COORD_BITS-1:0] req_pt_z,
   input  logic                         req_end_of_curve,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_cp_x,
   output logic signed [COORD_BITS-1:0] rsp_cp_y,
   output logic signed [COORD_BITS-1:0] rsp_cp_z,
   output logic [1:0]                   rsp_point_kind,
   output logic                         rsp_last_of_polygon
);

   localparam int PROD_W = COORD_BITS + COEF_FRAC_BITS + 2;

   // nine-point window, oldest at index 0; frozen while a burst is pending
   logic signed [COORD_BITS-1:0] win_ff [WIN_DEPTH][COORDS];
   logic signed [COORD_BITS-1:0] win_in [WIN_DEPTH][COORDS];
   logic [3:0]                   seen_ff, seen_in;
   logic                         parity_ff, parity_in;
   logic [JOB_COUNT-1:0]         pend_ff, pend_in;
   logic [JOB_COUNT-1:0]         new_jobs;
   logic [JOB_COUNT-1:0]         issue_mask;
   logic [JOB_COUNT-1:0]         pend_rest;
   logic                         accept;
   logic                         is_ninth;
   logic                         full_before;
   logic                         credit_ok;
   issue_type                    issue;
   pipe_status_type              pipe_status;
   result_tag_type               res_tag;
   logic signed [COORD_BITS-1:0] res_pt  [COORDS];
   logic signed [COORD_BITS-1:0] rd_pt   [COORDS];
   logic signed [PROD_W-1:0]     lane_prod [TAPS][COORDS];
   logic [FIFO_CNT_W-1:0]        fifo_count;
   logic [FIFO_CNT_W-1:0]        inflight;

   assign accept      = req_valid && !req_stall;
   assign is_ninth    = (seen_ff == 4'(WIN_DEPTH - 1));
   assign full_before = (seen_ff >= 4'(WIN_DEPTH));

   // jobs caused by the incoming item
   always_comb begin
      new_jobs = '0;
      if (is_ninth) begin
         new_jobs[JOB_FIRST]  = 1'b1;
         new_jobs[JOB_START5] = 1'b1;
         new_jobs[JOB_START7] = 1'b1;
      end else if (full_before && !parity_ff) begin
         new_jobs[JOB_REG] = 1'b1;
      end
      if (req_end_of_curve && (is_ninth || full_before)) begin
         new_jobs[JOB_END7] = 1'b1;
         new_jobs[JOB_END5] = 1'b1;
         new_jobs[JOB_LAST] = 1'b1;
      end
   end

   // queue credit: room for everything already in flight plus one more
   assign inflight  = FIFO_CNT_W'(pipe_status.s1_valid) + FIFO_CNT_W'(pipe_status.s2_valid);
   assign credit_ok = (fifo_count + inflight) < FIFO_CNT_W'(FIFO_DEPTH);

   // lowest pending job goes first, which is output order
   always_comb begin
      issue.valid = 1'b0;
      issue.job   = JOB_FIRST;
      issue_mask  = '0;
      for (int j = JOB_COUNT - 1; j >= 0; j--) begin
         if (pend_ff[j] && credit_ok) begin
            issue.valid = 1'b1;
            issue.job   = job_type'(3'(j));
            issue_mask  = JOB_COUNT'(1) << j;
         end
      end
   end

   assign pend_rest = pend_ff & ~issue_mask;
   assign req_stall = (pend_rest != '0);

   always_comb begin
      pend_in = accept ? (pend_rest | new_jobs) : pend_rest;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      seen_in   = seen_ff;
      parity_in = parity_ff;
      if (accept) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[WIN_DEPTH - 1][0] = req_pt_x;
         win_in[WIN_DEPTH - 1][1] = req_pt_y;
         win_in[WIN_DEPTH - 1][2] = req_pt_z;
         if (req_end_of_curve) begin
            // a new curve starts with the next item
            seen_in   = '0;
            parity_in = 1'b0;
         end else begin
            if (seen_ff < 4'(WIN_DEPTH)) begin
               seen_in = seen_ff + 4'd1;
            end
            parity_in = !parity_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         parity_ff <= 1'b0;
         pend_ff   <= '0;
      end else begin
         seen_ff   <= seen_in;
         parity_ff <= parity_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   // seven tap lanes; forward masks read from the oldest end, mirrored ones from the newest
   for (genvar t = 0; t < TAPS; t++) begin : g_lane
      rsoc_lane #(
         .COORD_BITS     (COORD_BITS),
         .COEF_FRAC_BITS (COEF_FRAC_BITS),
         .TAP            (t)
      ) u_lane (
         .clock  (clock),
         .job    (issue.job),
         .fwd_pt (win_ff[t]),
         .rev_pt (win_ff[WIN_DEPTH - 1 - t]),
         .prod   (lane_prod[t])
      );
   end

   rsoc_merge #(
      .COORD_BITS     (COORD_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .lane_prod (lane_prod),
      .status    (pipe_status),
      .res_tag   (res_tag),
      .res_pt    (res_pt)
   );

   rsoc_fifo #(
      .COORD_BITS (COORD_BITS)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_tag   (res_tag),
      .wr_pt    (res_pt),
      .rd_stall (rsp_stall),
      .rd_valid (rsp_valid),
      .rd_pt    (rd_pt),
      .rd_kind  (rsp_point_kind),
      .rd_last  (rsp_last_of_polygon),
      .count    (fifo_count)
   );

   assign rsp_cp_x = rd_pt[0];
   assign rsp_cp_y = rd_pt[1];
   assign rsp_cp_z = rd_pt[2];

   // queue never overcommitted
   a_credit : assert property (@(posedge clock) disable iff (reset)
      (fifo_count + inflight) <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overcommitted");

   // a start burst and a regular point never share one item
   a_no_mix : assert property (@(posedge clock) disable iff (reset)
      !(pend_ff[JOB_REG] && (pend_ff[JOB_FIRST] || pend_ff[JOB_START7])))
      else $error("regular job mixed with start burst");

   // ninth item of a curve loads the endpoint copy
   a_ninth : assert property (@(posedge clock) disable iff (reset)
      (accept && is_ninth) |=> pend_ff[JOB_FIRST])
      else $error("start burst not loaded on ninth item");

   // polygon closes only on an endpoint copy
   a_last_kind : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_polygon) |-> (rsp_point_kind == KIND_COPY))
      else $error("last control point is not an endpoint copy");

endmodule

FILE: tb/reverse_subdivision_open_curve_top_test.sv
// self-checking testbench for the streamed reverse subdivision of an open curve
`timescale 1ns / 1ps

module reverse_subdivision_open_curve_top_test;
   import rsoc_pkg::*;

   localparam int COORD_W    = 16;
   localparam int FRAC_W     = 14;
   // cycles with nothing accepted on either side before the run is abandoned
   localparam int QUIET_LIMIT = 2000;
   // receiver hold-off used to fill the block and back up the input
   localparam int HOLD_CYCLES = 90;
   // least number of random items per idling phase; the last curve may run past it
   localparam int PHASE_ITEMS = 105;
   // settle time after the last expected point, well past the pipeline depth
   localparam int TAIL_CYCLES = 16;

   typedef logic signed [COORD_W-1:0] coord_t;

   typedef struct packed {
      coord_t     cp_x;
      coord_t     cp_y;
      coord_t     cp_z;
      logic [1:0] kind;
      logic       last;
   } coarse_point_t;

   typedef enum int {
      MASK_START5,
      MASK_START7,
      MASK_REGULAR
   } mask_sel_t;

   // how a directed row gets its expected points
   typedef enum int {
      GLANCE_PREDICT,
      GLANCE_NO_POINTS,
      GLANCE_ZERO_BURST
   } glance_t;

   typedef struct {
      coord_t  x;
      coord_t  y;
      coord_t  z;
      bit      eoc;
      glance_t glance;
   } fine_row_t;

   // dut ports; the driven ones are known from time zero
   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_stall;
   coord_t req_pt_x = '0;
   coord_t req_pt_y = '0;
   coord_t req_pt_z = '0;
   logic   req_end_of_curve = 1'b0;
   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   coord_t rsp_cp_x;
   coord_t rsp_cp_y;
   coord_t rsp_cp_z;
   logic [1:0] rsp_point_kind;
   logic   rsp_last_of_polygon;

   // predictor state: nine-point window, oldest first, plus curve position
   coord_t curve_window [WIN_DEPTH][COORDS];
   int     fill_count = 0;
   bit     odd_index = 1'b0;

   coarse_point_t expected_points [$];
   coarse_point_t step_points [$];
   fine_row_t     directed_rows [$];
   coarse_point_t head_point;

   // idling controls, written by the stimulus process only
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_go = 1'b0;

   // owned by the receiving process
   bit hold_taken = 1'b0;
   int hold_left = 0;

   // run statistics
   int mismatches = 0;
   int points_sent = 0;
   int points_checked = 0;
   int curves_closed = 0;
   int short_curves = 0;
   int saturated_coords = 0;
   int phase_sent = 0;

   reverse_subdivision_open_curve_top #(
      .COORD_BITS(COORD_W),
      .COEF_FRAC_BITS(FRAC_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pt_x(req_pt_x),
      .req_pt_y(req_pt_y),
      .req_pt_z(req_pt_z),
      .req_end_of_curve(req_end_of_curve),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cp_x(rsp_cp_x),
      .rsp_cp_y(rsp_cp_y),
      .rsp_cp_z(rsp_cp_z),
      .rsp_point_kind(rsp_point_kind),
      .rsp_last_of_polygon(rsp_last_of_polygon)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // mask taps in millionths
   function automatic longint mask_ppm(mask_sel_t m, int tap);
      longint v;
      v = 0;
      case (m)
         MASK_START5: begin
            case (tap)
               0: v = -352518;
               1: v = 705036;
               2: v = 971230;
               3: v = -431655;
               4: v = 107914;
               default: v = 0;
            endcase
         end
         MASK_START7: begin
            case (tap)
               0: v = 180000;
               1: v = -360000;
               2: v = -80000;
               3: v = 1280000;
               4: v = 430000;
               5: v = -600000;
               6: v = 150000;
               default: v = 0;
            endcase
         end
         default: begin
            case (tap)
               0, 6: v = 117347;
               1, 5: v = -469388;
               2, 4: v = 321429;
               3: v = 1061224;
               default: v = 0;
            endcase
         end
      endcase
      return v;
   endfunction

   // millionths to q2.14, nearest with halves away from zero
   function automatic longint q14_coef(longint ppm);
      longint scaled;
      longint mag;
      longint r;
      scaled = ppm * (longint'(1) <<< FRAC_W);
      mag = (scaled < 0) ? -scaled : scaled;
      r = (mag + 500000) / 1000000;
      return (scaled < 0) ? -r : r;
   endfunction

   // drop the fraction bits of an exact sum, halves away from zero
   function automatic longint round_q14(longint acc);
      longint mag;
      longint r;
      mag = (acc < 0) ? -acc : acc;
      r = (mag + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      return (acc < 0) ? -r : r;
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi || v < lo) saturated_coords++;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic coarse_point_t make_point(coord_t x, coord_t y, coord_t z,
                                                logic [1:0] kind, logic last);
      coarse_point_t r;
      r.cp_x = x;
      r.cp_y = y;
      r.cp_z = z;
      r.kind = kind;
      r.last = last;
      return r;
   endfunction

   // reversed masks run from the newest point backwards, for the curve end
   function automatic coarse_point_t mask_point(mask_sel_t m, bit reversed, logic [1:0] kind);
      longint acc;
      longint sums [COORDS];
      int     taps;
      int     c;
      int     t;
      int     p;
      taps = (m == MASK_START5) ? 5 : 7;
      for (c = 0; c < COORDS; c++) begin
         acc = 0;
         for (t = 0; t < taps; t++) begin
            p = reversed ? WIN_DEPTH - 1 - t : t;
            acc += q14_coef(mask_ppm(m, t)) * longint'(curve_window[p][c]);
         end
         sums[c] = clamp_coord(round_q14(acc));
      end
      return make_point(coord_t'(sums[0]), coord_t'(sums[1]), coord_t'(sums[2]), kind, 1'b0);
   endfunction

   // advance the curve by one fine point; the coarse points it causes go to step_points
   task automatic predict_point(coord_t px, coord_t py, coord_t pz, bit eoc);
      bit full_before;
      bit ninth;
      int i;
      int c;
      full_before = (fill_count >= WIN_DEPTH);
      ninth = (fill_count == WIN_DEPTH - 1);
      for (i = 0; i < WIN_DEPTH - 1; i++)
         for (c = 0; c < COORDS; c++)
            curve_window[i][c] = curve_window[i + 1][c];
      curve_window[WIN_DEPTH - 1][0] = px;
      curve_window[WIN_DEPTH - 1][1] = py;
      curve_window[WIN_DEPTH - 1][2] = pz;
      step_points.delete();
      if (ninth) begin
         step_points = {step_points, make_point(curve_window[0][0], curve_window[0][1],
                                                curve_window[0][2], KIND_COPY, 1'b0)};
         step_points = {step_points, mask_point(MASK_START5, 1'b0, KIND_TAP5)};
         step_points = {step_points, mask_point(MASK_START7, 1'b0, KIND_TAP7)};
      end else if (full_before && !odd_index) begin
         step_points = {step_points, mask_point(MASK_REGULAR, 1'b0, KIND_REGULAR)};
      end
      if (eoc) begin
         if (ninth || full_before) begin
            step_points = {step_points, mask_point(MASK_START7, 1'b1, KIND_TAP7)};
            step_points = {step_points, mask_point(MASK_START5, 1'b1, KIND_TAP5)};
            step_points = {step_points, make_point(px, py, pz, KIND_COPY, 1'b1)};
         end else begin
            short_curves++;
         end
         curves_closed++;
         fill_count = 0;
         odd_index = 1'b0;
      end else begin
         if (fill_count < WIN_DEPTH) fill_count++;
         odd_index = !odd_index;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("coarse point %0d %s got %0d want %0d",
                                   points_checked, name, got, want));
   endtask

   // result side: check every accepted point, then pick the next stall value
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected coarse point (%0d,%0d,%0d) kind %0d",
                                      rsp_cp_x, rsp_cp_y, rsp_cp_z, rsp_point_kind));
         end else begin
            head_point = expected_points.pop_front();
            check_field("cp_x", rsp_cp_x, head_point.cp_x);
            check_field("cp_y", rsp_cp_y, head_point.cp_y);
            check_field("cp_z", rsp_cp_z, head_point.cp_z);
            check_field("point_kind", rsp_point_kind, head_point.kind);
            check_field("last_of_polygon", rsp_last_of_polygon, head_point.last);
            points_checked++;
         end
      end
      // one long hold-off, counted here, so the block fills and stalls its input
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   // watchdog: give up after a long stretch with no item moving either way
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: nothing accepted for %0d cycles, %0d points still expected",
               QUIET_LIMIT, expected_points.size());
      $display("[reverse_subdivision_open_curve_top] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   // edge values half the time, small values or full-range noise otherwise, so every bit toggles
   function automatic coord_t rand_coord();
      coord_t v;
      case ($urandom_range(0, 5))
         0: v = 16'sh7fff;
         1: v = 16'sh8000;
         2: v = '0;
         3: v = coord_t'(int'($urandom_range(0, 600)) - 300);
         default: v = coord_t'($urandom);
      endcase
      return v;
   endfunction

   // offer one fine point and wait for it to be taken; gaps come first
   task automatic offer_point(coord_t px, coord_t py, coord_t pz, bit eoc);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pt_x <= px;
      req_pt_y <= py;
      req_pt_z <= pz;
      req_end_of_curve <= eoc;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      points_sent++;
   endtask

   task automatic send_and_predict(coord_t px, coord_t py, coord_t pz, bit eoc);
      offer_point(px, py, pz, eoc);
      predict_point(px, py, pz, eoc);
      expected_points = {expected_points, step_points};
      phase_sent++;
   endtask

   // one curve of random points; a noisy curve may also end early at random
   task automatic send_curve(int length, bit noisy);
      int k;
      bit eoc;
      for (k = 0; k < length; k++) begin
         eoc = (k == length - 1) || (noisy && $urandom_range(0, 7) == 0);
         send_and_predict(rand_coord(), rand_coord(), rand_coord(), eoc);
      end
   endtask

   // lower valid and hold the input back until every expected point is out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() > 0) @(posedge clock);
   endtask

   task automatic add_row(coord_t x, coord_t y, coord_t z, bit eoc, glance_t g);
      fine_row_t row;
      row.x = x;
      row.y = y;
      row.z = z;
      row.eoc = eoc;
      row.glance = g;
      directed_rows = {directed_rows, row};
   endtask

   initial begin : stimulus
      int i;
      int r;
      int phase;
      fine_row_t row;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      // a curve of nine zero points right after reset: six zero points on the ninth
      for (i = 0; i < 8; i++) add_row('0, '0, '0, 1'b0, GLANCE_NO_POINTS);
      add_row('0, '0, '0, 1'b1, GLANCE_ZERO_BURST);
      // short curve of extremes gives nothing, and the next point starts afresh
      add_row(16'sh7fff, 16'sh8000, '0, 1'b0, GLANCE_NO_POINTS);
      add_row(16'sh8000, 16'sh7fff, -16'sd1, 1'b0, GLANCE_NO_POINTS);
      add_row(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1, GLANCE_NO_POINTS);
      // a single point that is its own curve end
      add_row(16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, GLANCE_NO_POINTS);
      // eleven alternating extremes: start burst, a regular point with the end, saturation
      for (i = 0; i < 11; i++)
         add_row((i % 2) ? 16'sh8000 : 16'sh7fff, (i % 2) ? 16'sh7fff : 16'sh8000,
                 16'sh8000, (i == 10), GLANCE_PREDICT);

      tx_idle_pct = 26;
      rx_idle_pct = 50;
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         offer_point(row.x, row.y, row.z, row.eoc);
         predict_point(row.x, row.y, row.z, row.eoc);
         case (row.glance)
            GLANCE_PREDICT: begin
               expected_points = {expected_points, step_points};
            end
            GLANCE_ZERO_BURST: begin
               expected_points = {expected_points, make_point('0, '0, '0, KIND_COPY, 1'b0)};
               expected_points = {expected_points, make_point('0, '0, '0, KIND_TAP5, 1'b0)};
               expected_points = {expected_points, make_point('0, '0, '0, KIND_TAP7, 1'b0)};
               expected_points = {expected_points, make_point('0, '0, '0, KIND_TAP7, 1'b0)};
               expected_points = {expected_points, make_point('0, '0, '0, KIND_TAP5, 1'b0)};
               expected_points = {expected_points, make_point('0, '0, '0, KIND_COPY, 1'b1)};
            end
            default: ;
         endcase
      end

      // random curves in three idling phases; each phase starts from an empty block
      for (phase = 0; phase < 3; phase++) begin
         drain_results();
         case (phase)
            0: begin tx_idle_pct = 26; rx_idle_pct = 50; end
            1: begin tx_idle_pct = 50; rx_idle_pct = 26; end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               // long receiver hold-off while points keep coming
               hold_go = 1'b1;
            end
         endcase
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 15)      send_curve($urandom_range(1, 8), 1'b0);
            else if (r < 25) send_curve(9, 1'b0);
            else if (r < 35) send_curve(10, 1'b0);
            else if (r < 85) send_curve($urandom_range(11, 24), 1'b0);
            else             send_curve($urandom_range(9, 30), 1'b1);
         end
      end

      // close any curve still open so its end burst is checked too
      if (fill_count != 0) send_and_predict(rand_coord(), rand_coord(), rand_coord(), 1'b1);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_points.size() > 0)
         report_mismatch($sformatf("%0d coarse points never arrived", expected_points.size()));

      $display("covered %0d fine points in %0d curves (%0d too short for a polygon)",
               points_sent, curves_closed, short_curves);
      $display("checked %0d coarse points, %0d saturated coordinates, %0d mismatches",
               points_checked, saturated_coords, mismatches);
      if (mismatches == 0) begin
         $display("[reverse_subdivision_open_curve_top] OK");
      end else begin
         $display("[reverse_subdivision_open_curve_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rsoc_pkg.sv
hw/rtl/rsoc_lane.sv
hw/rtl/rsoc_merge.sv
hw/rtl/rsoc_fifo.sv
hw/rtl/reverse_subdivision_open_curve_top.sv
tb/reverse_subdivision_open_curve_top_test.sv
